[sv/color_sensor_white_balance_top_assert.svh]
// Assertion macros shared by the white-balance block.
// Define NO_ASSERTIONS to compile every check away; no other dependencies.
`ifndef COLOR_SENSOR_WHITE_BALANCE_TOP_ASSERT_SVH
`define COLOR_SENSOR_WHITE_BALANCE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// prop must hold at every clock edge outside reset
`define CSWB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// expr must never be true outside reset
`define CSWB_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define CSWB_ASSERT(lbl, clk, rstn, prop, msg)
`define CSWB_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

[sv/cswb_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants of the color sensor white-balance block.
// No dependencies.
package cswb_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int GATE_W         = 16;
    localparam int SCALE_W        = 2;
    localparam int FILTER_W       = 2;
    localparam int LEVEL_W        = 8;
    localparam int FACTOR_W       = 24;
    localparam int FRAC_BITS      = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 16;
    localparam int NUM_CH         = 3;
    localparam int AVG_WINDOWS    = 3;

    localparam logic [GATE_W-1:0]   GATE_RESET   = 16'd1000;
    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 2'd3;
    localparam logic [FACTOR_W-1:0] FACTOR_MAX   = 24'hFF_FFFF;
    localparam logic [FACTOR_W-1:0] FULL_SCALE_Q = 24'hFF_0000;

    // command codes on s_cmd
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_CAL  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_SCALE = 1'b1;

    // S2S3 filter drive codes
    localparam logic [FILTER_W-1:0] FILT_RED   = 2'b00;
    localparam logic [FILTER_W-1:0] FILT_BLUE  = 2'b01;
    localparam logic [FILTER_W-1:0] FILT_CLEAR = 2'b10;
    localparam logic [FILTER_W-1:0] FILT_GREEN = 2'b11;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_BLUE  = 2'd1;
    localparam logic [1:0] CH_GREEN = 2'd2;
    localparam logic [1:0] CH_LAST  = 2'(NUM_CH - 1);
    localparam logic [1:0] REP_LAST = 2'(AVG_WINDOWS - 1);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CAL  = 2'd1,
        PH_READ = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CS_TICK     = 2'd0,
        CS_DIV_AVG  = 2'd1,
        CS_DIV_FACT = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic tick_en;         // process the transaction on the input channel
        logic fact_start;      // start 0xFF0000 / avg
        logic fact_max_write;  // zero average: store the maximum factor
        logic fact_write;      // store the divider quotient as the factor
    } dp_cmd_t;

    typedef struct packed {
        logic div_launch;      // the presented tick closes a calibration channel
        logic div_done;
        logic avg_zero;
        logic div_busy;
    } dp_status_t;

    function automatic logic [FILTER_W-1:0] filter_code(input logic [1:0] ch);
        logic [FILTER_W-1:0] code;
        unique case (ch)
            CH_RED:   code = FILT_RED;
            CH_BLUE:  code = FILT_BLUE;
            CH_GREEN: code = FILT_GREEN;
            default:  code = FILT_CLEAR;
        endcase
        return code;
    endfunction

endpackage

[sv/color_sensor_white_balance_top.sv]
`timescale 1ns / 1ps
// Top level of the color sensor white-balance block: controller plus datapath.
// Depends on cswb_pkg, cswb_ctrl, cswb_dp (which holds cswb_div).
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------------
//  input    | s_valid / s_ready  | s_cmd, s_pulse (one sensor tick)
//  result   | m_valid / m_ready  | m_filter_sel, m_scale_drive, m_*_level, done flags
//  config   | cfg_we             | cfg_index, cfg_data
//
// One tick per cycle while s_ready is high; a result sits in the output register while
// the next tick is taken. A tick that closes the third calibration window of a filter
// captures the sum; the next cycle forms sum / 3 by a reciprocal multiply and starts a
// serial divider for 0xFF0000 / avg, one bit per cycle over max(24, COUNT_BITS+2) bits:
// s_ready stays low until the factor is stored (the maximum factor on a zero average).
// Reset: synchronous active-low aresetn, factors at their maximum, levels zero.
module color_sensor_white_balance_top #(
    parameter int COUNT_BITS = cswb_pkg::COUNT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [cswb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cswb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_cmd,
    input  logic                               s_pulse,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [cswb_pkg::FILTER_W-1:0]      m_filter_sel,
    output logic [cswb_pkg::SCALE_W-1:0]       m_scale_drive,
    output logic [cswb_pkg::LEVEL_W-1:0]       m_red_level,
    output logic [cswb_pkg::LEVEL_W-1:0]       m_blue_level,
    output logic [cswb_pkg::LEVEL_W-1:0]       m_green_level,
    output logic                               m_cal_done,
    output logic                               m_read_done,
    output logic                               m_busy_res
);

    cswb_pkg::dp_cmd_t    dp_cmd;
    cswb_pkg::dp_status_t dp_status;

    cswb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (dp_status),
        .cmd     (dp_cmd)
    );

    cswb_dp #(
        .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_cmd         (s_cmd),
        .s_pulse       (s_pulse),
        .cmd           (dp_cmd),
        .status        (dp_status),
        .m_filter_sel  (m_filter_sel),
        .m_scale_drive (m_scale_drive),
        .m_red_level   (m_red_level),
        .m_blue_level  (m_blue_level),
        .m_green_level (m_green_level),
        .m_cal_done    (m_cal_done),
        .m_read_done   (m_read_done),
        .m_busy_res    (m_busy_res)
    );

endmodule

[sv/cswb_div.sv]
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per cycle.
// Uses no package items.
module cswb_div #(
    parameter int W = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         busy,
    output logic         done,
    output logic [W-1:0] quot
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quot_reg, quot_next;
    logic [W-1:0]  den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [W:0] shifted;
    logic [W:0] diff;
    logic       ge;

    always_comb begin
        shifted   = {rem_reg, quot_reg[W-1]};
        diff      = shifted - {1'b0, den_reg};
        ge        = !diff[W];
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quot_next = num;
            den_next  = den;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[W-1:0] : shifted[W-1:0];
            quot_next = {quot_reg[W-2:0], ge};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[sv/cswb_dp.sv]
`timescale 1ns / 1ps
// Datapath: window counters, calibration factors, levels, config and result registers.
// Depends on cswb_pkg, cswb_div and the assertion macro header.
`include "color_sensor_white_balance_top_assert.svh"
module cswb_dp #(
    parameter int COUNT_BITS = cswb_pkg::COUNT_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [cswb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cswb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [1:0]                          s_cmd,
    input  logic                                s_pulse,
    input  cswb_pkg::dp_cmd_t                   cmd,
    output cswb_pkg::dp_status_t                status,
    output logic [cswb_pkg::FILTER_W-1:0]       m_filter_sel,
    output logic [cswb_pkg::SCALE_W-1:0]        m_scale_drive,
    output logic [cswb_pkg::LEVEL_W-1:0]        m_red_level,
    output logic [cswb_pkg::LEVEL_W-1:0]        m_blue_level,
    output logic [cswb_pkg::LEVEL_W-1:0]        m_green_level,
    output logic                                m_cal_done,
    output logic                                m_read_done,
    output logic                                m_busy_res
);

    localparam int SUM_W  = COUNT_BITS + 2;
    localparam int DIV_W  = (SUM_W > cswb_pkg::FACTOR_W) ? SUM_W : cswb_pkg::FACTOR_W;
    localparam int PROD_W = COUNT_BITS + cswb_pkg::FACTOR_W;
    localparam int GW     = cswb_pkg::GATE_W;
    localparam int FW     = cswb_pkg::FACTOR_W;
    localparam int LW     = cswb_pkg::LEVEL_W;

    // sum / 3 as (sum * ceil(2^K / 3)) >> K, exact for every sum below 2^SUM_W
    localparam int RECIP_K = SUM_W + 1;
    localparam int AVG_PW  = 2 * SUM_W;
    localparam logic [SUM_W-1:0] RECIP_3 =
        SUM_W'(((longint'(1) << RECIP_K) + longint'(2)) / longint'(3));

    // configuration
    logic [GW-1:0]                    gate_reg;
    logic [cswb_pkg::SCALE_W-1:0]     scale_reg;

    // architectural state
    cswb_pkg::phase_t                 phase_reg, phase_next;
    logic [1:0]                       channel_reg, channel_next;
    logic [1:0]                       rep_reg, rep_next;
    logic [GW-1:0]                    tick_reg, tick_next;
    logic [COUNT_BITS-1:0]            pc_reg, pc_next;
    logic [SUM_W-1:0]                 sum_reg, sum_next;
    logic [FW-1:0]                    factor_reg [cswb_pkg::NUM_CH];
    logic [LW-1:0]                    level_reg [cswb_pkg::NUM_CH];
    logic [1:0]                       div_ch_reg;
    logic [SUM_W-1:0]                 cal_sum_reg;

    // result register
    logic [cswb_pkg::FILTER_W-1:0]    out_filter_reg;
    logic [cswb_pkg::SCALE_W-1:0]     out_scale_reg;
    logic [LW-1:0]                    out_level_reg [cswb_pkg::NUM_CH];
    logic                             out_cal_done_reg;
    logic                             out_read_done_reg;
    logic                             out_busy_reg;

    logic [GW-1:0]          gate_eff;
    logic [GW-1:0]          tc_inc;
    logic [COUNT_BITS-1:0]  pc_inc;
    logic [SUM_W-1:0]       sum_inc;
    logic [FW-1:0]          factor_sel;
    logic [PROD_W-1:0]      prod;
    logic [LW-1:0]          lvl_val;
    logic                   lvl_we;
    logic                   launch;
    logic                   cal_done_next;
    logic                   read_done_next;
    logic                   channel_end;
    logic [cswb_pkg::FILTER_W-1:0] filter_next;

    logic [AVG_PW-1:0]      avg_prod;
    logic [DIV_W-1:0]       avg_val;
    logic                   div_start;
    logic [DIV_W-1:0]       div_num;
    logic [DIV_W-1:0]       div_den;
    logic                   div_busy;
    logic                   div_done;
    logic [DIV_W-1:0]       div_quot;

    always_comb begin
        gate_eff = (gate_reg == '0) ? GW'(1) : gate_reg;
        tc_inc   = (tick_reg != '1) ? tick_reg + GW'(1) : tick_reg;
        pc_inc   = (s_pulse && pc_reg != '1) ? pc_reg + COUNT_BITS'(1) : pc_reg;
        sum_inc  = sum_reg + SUM_W'(pc_inc);
        unique case (channel_reg)
            cswb_pkg::CH_RED:   factor_sel = factor_reg[0];
            cswb_pkg::CH_BLUE:  factor_sel = factor_reg[1];
            cswb_pkg::CH_GREEN: factor_sel = factor_reg[2];
            default:            factor_sel = factor_reg[0];
        endcase
        prod    = PROD_W'(pc_inc) * PROD_W'(factor_sel);
        lvl_val = (|prod[PROD_W-1:cswb_pkg::FRAC_BITS+LW]) ? '1
                : prod[cswb_pkg::FRAC_BITS +: LW];
    end

    // next state of one tick, committed only when the tick is accepted
    always_comb begin
        phase_next     = phase_reg;
        channel_next   = channel_reg;
        rep_next       = rep_reg;
        tick_next      = tick_reg;
        pc_next        = pc_reg;
        sum_next       = sum_reg;
        lvl_we         = 1'b0;
        launch         = 1'b0;
        cal_done_next  = 1'b0;
        read_done_next = 1'b0;
        channel_end    = 1'b1;
        if (phase_reg == cswb_pkg::PH_IDLE) begin
            if (s_cmd == cswb_pkg::CMD_CAL || s_cmd == cswb_pkg::CMD_READ) begin
                phase_next   = (s_cmd == cswb_pkg::CMD_CAL) ? cswb_pkg::PH_CAL
                                                            : cswb_pkg::PH_READ;
                channel_next = '0;
                rep_next     = '0;
                sum_next     = '0;
                tick_next    = '0;
                pc_next      = '0;
            end
        end else begin
            tick_next = tc_inc;
            pc_next   = pc_inc;
            if (tc_inc >= gate_eff && channel_reg <= cswb_pkg::CH_LAST) begin
                if (phase_reg == cswb_pkg::PH_CAL) begin
                    if (rep_reg < cswb_pkg::REP_LAST) begin
                        sum_next    = sum_inc;
                        rep_next    = rep_reg + 2'd1;
                        channel_end = 1'b0;
                    end else begin
                        launch   = 1'b1;
                        sum_next = '0;
                        rep_next = '0;
                    end
                end else begin
                    lvl_we = 1'b1;
                end
                tick_next = '0;
                pc_next   = '0;
                if (channel_end) begin
                    if (channel_reg < cswb_pkg::CH_LAST) begin
                        channel_next = channel_reg + 2'd1;
                    end else begin
                        cal_done_next  = (phase_reg == cswb_pkg::PH_CAL);
                        read_done_next = (phase_reg != cswb_pkg::PH_CAL);
                        phase_next     = cswb_pkg::PH_IDLE;
                        channel_next   = '0;
                    end
                end
            end else if (channel_reg > cswb_pkg::CH_LAST) begin
                phase_next   = cswb_pkg::PH_IDLE;
                channel_next = '0;
            end
        end
        filter_next = (phase_next == cswb_pkg::PH_IDLE) ? cswb_pkg::FILT_CLEAR
                    : cswb_pkg::filter_code(channel_next);
    end

    // average from the captured sum in the cycle after the launch, then 0xFF0000 / avg
    always_comb begin
        avg_prod  = AVG_PW'(cal_sum_reg) * AVG_PW'(RECIP_3);
        avg_val   = DIV_W'(avg_prod >> RECIP_K);
        div_start = cmd.fact_start;
        div_num   = DIV_W'(cswb_pkg::FULL_SCALE_Q);
        div_den   = avg_val;
    end

    cswb_div #(
        .W(DIV_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_reg    <= cswb_pkg::GATE_RESET;
            scale_reg   <= cswb_pkg::SCALE_RESET;
            phase_reg   <= cswb_pkg::PH_IDLE;
            channel_reg <= '0;
            rep_reg     <= '0;
            tick_reg    <= '0;
            pc_reg      <= '0;
            sum_reg     <= '0;
            div_ch_reg  <= '0;
            cal_sum_reg <= '0;
            for (int i = 0; i < cswb_pkg::NUM_CH; i++) begin
                factor_reg[i] <= cswb_pkg::FACTOR_MAX;
                level_reg[i]  <= '0;
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    cswb_pkg::CFG_GATE_TICKS: gate_reg <= cfg_data[GW-1:0];
                    cswb_pkg::CFG_FREQ_SCALE: scale_reg <= cfg_data[cswb_pkg::SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.tick_en) begin
                phase_reg   <= phase_next;
                channel_reg <= channel_next;
                rep_reg     <= rep_next;
                tick_reg    <= tick_next;
                pc_reg      <= pc_next;
                sum_reg     <= sum_next;
                if (launch) begin
                    div_ch_reg  <= channel_reg;
                    cal_sum_reg <= sum_inc;
                end
                if (lvl_we) begin
                    for (int i = 0; i < cswb_pkg::NUM_CH; i++) begin
                        if (channel_reg == 2'(i)) begin
                            level_reg[i] <= lvl_val;
                        end
                    end
                end
            end
            if (cmd.fact_write || cmd.fact_max_write) begin
                for (int i = 0; i < cswb_pkg::NUM_CH; i++) begin
                    if (div_ch_reg == 2'(i)) begin
                        factor_reg[i] <= cmd.fact_write ? div_quot[FW-1:0]
                                                        : cswb_pkg::FACTOR_MAX;
                    end
                end
            end
        end
    end

    // result register, loaded with the state after the accepted tick
    always_ff @(posedge aclk) begin
        if (cmd.tick_en) begin
            out_filter_reg    <= filter_next;
            out_scale_reg     <= scale_reg;
            out_cal_done_reg  <= cal_done_next;
            out_read_done_reg <= read_done_next;
            out_busy_reg      <= (phase_next != cswb_pkg::PH_IDLE);
            for (int i = 0; i < cswb_pkg::NUM_CH; i++) begin
                out_level_reg[i] <= (lvl_we && channel_reg == 2'(i)) ? lvl_val
                                  : level_reg[i];
            end
        end
    end

    always_comb begin
        status.div_launch = launch;
        status.div_done   = div_done;
        status.avg_zero   = (avg_val == '0);
        status.div_busy   = div_busy;
    end

    assign m_filter_sel  = out_filter_reg;
    assign m_scale_drive = out_scale_reg;
    assign m_red_level   = out_level_reg[0];
    assign m_blue_level  = out_level_reg[1];
    assign m_green_level = out_level_reg[2];
    assign m_cal_done    = out_cal_done_reg;
    assign m_read_done   = out_read_done_reg;
    assign m_busy_res    = out_busy_reg;

    `CSWB_ASSERT_NEVER(a_no_tick_during_div, aclk, aresetn,
        div_busy && cmd.tick_en, "tick taken while the divider runs")
    `CSWB_ASSERT(a_done_clears_busy, aclk, aresetn,
        (cmd.tick_en && (cal_done_next || read_done_next)) |=> !m_busy_res,
        "sequence finished but busy still set")

endmodule

[sv/cswb_ctrl.sv]
`timescale 1ns / 1ps
// Controller: input/output handshake and sequencing of the factor division.
// Depends on cswb_pkg and the assertion macro header.
`include "color_sensor_white_balance_top_assert.svh"
module cswb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  cswb_pkg::dp_status_t  status,
    output cswb_pkg::dp_cmd_t     cmd
);

    cswb_pkg::ctrl_state_t state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cswb_pkg::CS_TICK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            cswb_pkg::CS_TICK: begin
                s_ready     = !m_valid_reg || m_ready;
                cmd.tick_en = s_valid && s_ready;
                if (cmd.tick_en && status.div_launch) begin
                    state_next = cswb_pkg::CS_DIV_AVG;
                end
            end
            cswb_pkg::CS_DIV_AVG: begin
                // average of the captured sum is valid here, in the cycle after the launch
                if (status.avg_zero) begin
                    cmd.fact_max_write = 1'b1;
                    state_next         = cswb_pkg::CS_TICK;
                end else begin
                    cmd.fact_start = 1'b1;
                    state_next     = cswb_pkg::CS_DIV_FACT;
                end
            end
            cswb_pkg::CS_DIV_FACT: begin
                if (status.div_done) begin
                    cmd.fact_write = 1'b1;
                    state_next     = cswb_pkg::CS_TICK;
                end
            end
            default: begin
                state_next = cswb_pkg::CS_TICK;
            end
        endcase
        m_valid_next = cmd.tick_en ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    assign m_valid = m_valid_reg;

    `CSWB_ASSERT(a_launch_enters_div, aclk, aresetn,
        (cmd.tick_en && status.div_launch) |=> (state_reg == cswb_pkg::CS_DIV_AVG),
        "division launch not followed")
    `CSWB_ASSERT(a_fact_done_returns, aclk, aresetn,
        (state_reg == cswb_pkg::CS_DIV_FACT && status.div_done)
            |=> (state_reg == cswb_pkg::CS_TICK),
        "factor division did not finish the sequence")

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for color_sensor_white_balance_top: a tracker class predicts each
// tick's reading from the calibration/read sequencing; plain tasks drive ticks and config.
// Depends on cswb_pkg and the RTL of the block only.
module tb_top;
    import cswb_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;   // undefined command, acts as a plain tick
    localparam int DIV_SETTLE          = 64;     // divider passes after the last reading
    localparam int WATCHDOG_LIMIT      = 4000;
    localparam int LONG_HOLD           = 400;

    typedef struct packed {
        logic [FILTER_W-1:0] filter_sel;
        logic [SCALE_W-1:0]  scale_drive;
        logic [LEVEL_W-1:0]  red;
        logic [LEVEL_W-1:0]  blue;
        logic [LEVEL_W-1:0]  green;
        logic                cal_done;
        logic                read_done;
        logic                busy;
    } sensor_reading_t;

    // Tracks the controller state per accepted tick and holds the readings still due.
    class balance_tracker;
        logic [GATE_W-1:0]           gate_len;
        logic [SCALE_W-1:0]          scale_mode;
        phase_t                      ph;
        logic [1:0]                  chan;
        logic [1:0]                  rep;
        logic [15:0]                 ticks;
        logic [COUNT_BITS_DEF-1:0]   pulses;
        logic [COUNT_BITS_DEF+1:0]   sum;
        logic [FACTOR_W-1:0]         factor [NUM_CH];
        logic [LEVEL_W-1:0]          lvl [NUM_CH];
        sensor_reading_t             due_readings [$];
        int unsigned                 n_ticks, n_results, n_cal, n_read, n_err;

        function new();
            gate_len   = GATE_RESET;
            scale_mode = SCALE_RESET;
            ph         = PH_IDLE;
            chan       = CH_RED;
            rep        = '0;
            ticks      = '0;
            pulses     = '0;
            sum        = '0;
            foreach (factor[i]) begin
                factor[i] = FACTOR_MAX;
                lvl[i]    = '0;
            end
            n_ticks = 0; n_results = 0; n_cal = 0; n_read = 0; n_err = 0;
        endfunction

        function void take_tick(input logic [1:0] cmd, input logic pulse);
            logic [GATE_W-1:0]                  gate;
            logic [COUNT_BITS_DEF-1:0]          avg;
            logic [COUNT_BITS_DEF+FACTOR_W-1:0] prod;
            logic                               chan_end;
            sensor_reading_t                    r;
            r = '0;
            n_ticks++;
            if (ph == PH_IDLE) begin
                // the start tick only opens the first window
                if (cmd == CMD_CAL || cmd == CMD_READ) begin
                    if (cmd == CMD_CAL) ph = PH_CAL;
                    else ph = PH_READ;
                    chan = CH_RED; rep = '0; sum = '0; ticks = '0; pulses = '0;
                end
            end else begin
                gate = (gate_len == '0) ? GATE_W'(1) : gate_len;
                if (pulse && pulses != '1) pulses++;
                if (ticks != '1) ticks++;
                if (ticks >= gate) begin
                    chan_end = 1'b1;
                    if (ph == PH_CAL) begin
                        sum += pulses;
                        if (rep != REP_LAST) begin
                            rep++;
                            chan_end = 1'b0;
                        end else begin
                            avg = sum / AVG_WINDOWS;
                            factor[chan] = (avg == '0) ? FACTOR_MAX : FULL_SCALE_Q / avg;
                            sum = '0;
                            rep = '0;
                        end
                    end else begin
                        prod = pulses * factor[chan];
                        prod = prod >> FRAC_BITS;
                        lvl[chan] = (prod > 255) ? 8'hFF : prod[LEVEL_W-1:0];
                    end
                    ticks = '0;
                    pulses = '0;
                    if (chan_end) begin
                        if (chan != CH_LAST) begin
                            chan++;
                        end else begin
                            r.cal_done  = (ph == PH_CAL);
                            r.read_done = (ph == PH_READ);
                            n_cal  += r.cal_done;
                            n_read += r.read_done;
                            ph   = PH_IDLE;
                            chan = CH_RED;
                        end
                    end
                end
            end
            if (ph == PH_IDLE) begin
                r.filter_sel = FILT_CLEAR;
            end else begin
                case (chan)
                    CH_RED:  r.filter_sel = FILT_RED;
                    CH_BLUE: r.filter_sel = FILT_BLUE;
                    default: r.filter_sel = FILT_GREEN;
                endcase
            end
            r.scale_drive = scale_mode;
            r.red   = lvl[CH_RED];
            r.blue  = lvl[CH_BLUE];
            r.green = lvl[CH_GREEN];
            r.busy  = (ph != PH_IDLE);
            due_readings.push_back(r);
        endfunction

        function void same(input string name, input logic [31:0] want, input logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                n_err++;
            end
        endfunction

        function void match_reading(input sensor_reading_t got);
            sensor_reading_t want;
            n_results++;
            if (due_readings.size() == 0) begin
                $error("reading arrived with no tick outstanding");
                n_err++;
                return;
            end
            want = due_readings.pop_front();
            same("filter_sel",  want.filter_sel,  got.filter_sel);
            same("scale_drive", want.scale_drive, got.scale_drive);
            same("red_level",   want.red,         got.red);
            same("blue_level",  want.blue,        got.blue);
            same("green_level", want.green,       got.green);
            same("cal_done",    want.cal_done,    got.cal_done);
            same("read_done",   want.read_done,   got.read_done);
            same("busy_res",    want.busy,        got.busy);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_GATE_TICKS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_cmd     = CMD_TICK;
    logic                  s_pulse   = 1'b0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [FILTER_W-1:0]   m_filter_sel;
    logic [SCALE_W-1:0]    m_scale_drive;
    logic [LEVEL_W-1:0]    m_red_level;
    logic [LEVEL_W-1:0]    m_blue_level;
    logic [LEVEL_W-1:0]    m_green_level;
    logic                  m_cal_done;
    logic                  m_read_done;
    logic                  m_busy_res;

    balance_tracker tracker;
    int unsigned    tx_idle_pct = 7;
    int unsigned    rx_idle_pct = 87;
    int unsigned    light_pct   = 50;
    int unsigned    rx_hold_req = 0;

    color_sensor_white_balance_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_pulse       (s_pulse),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_filter_sel  (m_filter_sel),
        .m_scale_drive (m_scale_drive),
        .m_red_level   (m_red_level),
        .m_blue_level  (m_blue_level),
        .m_green_level (m_green_level),
        .m_cal_done    (m_cal_done),
        .m_read_done   (m_read_done),
        .m_busy_res    (m_busy_res)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // valid stays high after a transaction; the next call either changes payload or drops it
    task automatic send_tick(input logic [1:0] cmd, input logic pulse);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_pulse <= pulse;
        do @(posedge aclk); while (!s_ready);
        tracker.take_tick(cmd, pulse);
    endtask

    task automatic wait_drained();
        while (tracker.due_readings.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [1:0] stray_cmd();
        return ($urandom_range(7) == 0) ? 2'($urandom_range(3)) : CMD_TICK;
    endfunction

    function automatic logic [1:0] pick_start();
        int unsigned r;
        r = $urandom_range(19);
        if (r < 9) return CMD_CAL;
        if (r < 18) return CMD_READ;
        return (r == 18) ? CMD_TICK : CMD_UNUSED;
    endfunction

    function automatic int unsigned pick_light();
        case ($urandom_range(5))
            0: return 0;
            1: return 4;
            2: return 50;
            3: return 96;
            4: return 100;
            default: return $urandom_range(100);
        endcase
    endfunction

    function automatic logic [GATE_W-1:0] pick_gate(input int phase_no);
        if (phase_no == 0) return GATE_W'(1);
        if (phase_no == 1) return GATE_W'(32);
        case ($urandom_range(15))
            0: return '0;
            1: return GATE_W'($urandom_range(32, 48));
            default: return GATE_W'($urandom_range(1, 10));
        endcase
    endfunction

    task automatic finish_sequence();
        while (tracker.ph != PH_IDLE)
            send_tick(stray_cmd(), $urandom_range(99) < light_pct);
    endtask

    task automatic feed(input int n);
        logic [1:0] cmd;
        for (int i = 0; i < n; i++) begin
            if (tracker.ph == PH_IDLE) begin
                cmd = pick_start();
                light_pct = pick_light();
            end else begin
                cmd = stray_cmd();
            end
            send_tick(cmd, $urandom_range(99) < light_pct);
        end
    endtask

    // registers change only with the controller idle and the divider settled
    task automatic program_sensor(input logic [GATE_W-1:0] gate,
                                  input logic [SCALE_W-1:0] scale);
        finish_sequence();
        s_valid <= 1'b0;
        wait_drained();
        repeat (DIV_SETTLE) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GATE_TICKS;
        cfg_data  <= gate;
        @(posedge aclk);
        tracker.gate_len = gate;
        cfg_index <= CFG_FREQ_SCALE;
        cfg_data  <= CFG_DATA_W'(scale);
        @(posedge aclk);
        tracker.scale_mode = scale;
        cfg_we <= 1'b0;
    endtask

    // result side: check each transaction, then pick ready for the next cycle
    initial begin : result_side
        sensor_reading_t got;
        int unsigned     hold;
        hold = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got.filter_sel  = m_filter_sel;
                got.scale_drive = m_scale_drive;
                got.red         = m_red_level;
                got.blue        = m_blue_level;
                got.green       = m_green_level;
                got.cal_done    = m_cal_done;
                got.read_done   = m_read_done;
                got.busy        = m_busy_res;
                tracker.match_reading(got);
            end
            if (rx_hold_req != 0) begin
                hold = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold != 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        tracker = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: clear filter, full scale drive, zero levels
        send_tick(CMD_TICK, 1'b1);
        send_tick(CMD_UNUSED, 1'b0);
        // zero gate behaves as a one-tick window
        program_sensor('0, 2'd0);
        send_tick(CMD_CAL, 1'b1);        // start tick pulse is not counted
        send_tick(CMD_UNUSED, 1'b0);     // red: all windows empty, zero average
        send_tick(CMD_READ, 1'b0);
        send_tick(CMD_TICK, 1'b0);
        send_tick(CMD_CAL, 1'b1);        // blue: average of one
        send_tick(CMD_TICK, 1'b1);
        send_tick(CMD_TICK, 1'b1);
        send_tick(CMD_TICK, 1'b1);       // green: sum of two truncates to zero average
        send_tick(CMD_TICK, 1'b0);
        send_tick(CMD_TICK, 1'b1);
        send_tick(CMD_READ, 1'b1);       // large factors drive red and green levels to their maximum
        send_tick(CMD_TICK, 1'b1);
        send_tick(CMD_TICK, 1'b0);
        send_tick(CMD_TICK, 1'b1);
        send_tick(CMD_UNUSED, 1'b1);
        send_tick(CMD_TICK, 1'b0);

        for (int p = 0; p < 12; p++) begin
            if (p == 4) begin
                tx_idle_pct = 87;
                rx_idle_pct = 7;
            end
            if (p == 8) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            program_sensor(pick_gate(p), SCALE_W'(p % 4));
            if (p == 5) begin
                feed(30);
                s_valid <= 1'b0;
                wait_drained();
                feed(30);
            end else if (p == 10) begin
                feed(20);
                rx_hold_req = LONG_HOLD;   // sender keeps offering until the block backs up
                feed(60);
            end else begin
                feed($urandom_range(40, 60));
            end
        end

        // minimum practical gate with a sensor pulse on every tick
        program_sensor(GATE_W'(32), 2'd1);
        light_pct = 100;
        send_tick(CMD_READ, 1'b1);
        finish_sequence();

        s_valid <= 1'b0;
        wait_drained();
        repeat (DIV_SETTLE) @(posedge aclk);
        if (tracker.due_readings.size() != 0) begin
            $error("%0d readings never arrived", tracker.due_readings.size());
            tracker.n_err++;
        end
        $display("covered %0d ticks, %0d readings checked, %0d calibrations, %0d color reads",
                 tracker.n_ticks, tracker.n_results, tracker.n_cal, tracker.n_read);
        $display("gates 0, 1, 32 and random short ones; all four scale drives");
        if (tracker.n_err == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+sv
sv/cswb_pkg.sv
sv/cswb_div.sv
sv/cswb_dp.sv
sv/cswb_ctrl.sv
sv/color_sensor_white_balance_top.sv
bench/tb_top.sv
